/* hw/rtl/ptt_pkg.sv */
// shared constants and types for the periodic timeout table
package ptt_pkg;

   localparam int SLOTS   = 16;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int REQ_W   = 3;
   localparam int IDX_W   = 5;
   localparam int TIME_W  = 32;
   localparam int WAIT_W  = 31;
   localparam int USE_W   = 5;

   localparam logic [USE_W-1:0]  USE_RESET   = USE_W'(SLOTS);
   localparam logic [WAIT_W-1:0] NO_DEADLINE = 31'h7fff_ffff;

   typedef enum logic [REQ_W-1:0] {
      REQ_ENABLE      = 3'd0,
      REQ_DISABLE     = 3'd1,
      REQ_DISABLE_ALL = 3'd2,
      REQ_CLAIM       = 3'd3,
      REQ_QUERY       = 3'd4
   } req_code_type;

endpackage

/* hw/rtl/ptt_req_if.sv */
// request channel of the periodic timeout table
interface ptt_req_if;
   import ptt_pkg::*;

   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [IDX_W-1:0]    slot_index;
   logic [TIME_W-1:0]   period;
   logic [TIME_W-1:0]   now;

   modport source (output valid, output req_type, output slot_index, output period,
                   output now, input ready);
   modport sink   (input valid, input req_type, input slot_index, input period,
                   input now, output ready);
endinterface

/* hw/rtl/ptt_rsp_if.sv */
// response channel of the periodic timeout table
interface ptt_rsp_if;
   import ptt_pkg::*;

   logic                valid;
   logic                ready;
   logic                status;
   logic                expired_found;
   logic [SLOT_W-1:0]   expired_slot;
   logic [WAIT_W-1:0]   wait_time;

   modport source (output valid, output status, output expired_found,
                   output expired_slot, output wait_time, input ready);
   modport sink   (input valid, input status, input expired_found,
                   input expired_slot, input wait_time, output ready);
endinterface

/* hw/rtl/ptt_csr_if.sv */
// configuration write channel of the periodic timeout table
interface ptt_csr_if;
   import ptt_pkg::*;

   logic                valid;
   logic                ready;
   logic [USE_W-1:0]    data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/periodic_timeout_table.sv */
// periodic timeout table: one request at a time, slot periods and deadlines held in a ram
//
// Sixteen timeout slots. Each request is taken into a holding register and
// answered by exactly one response. Enable, disable, disable-all and unknown
// request codes pass through the execute and done states before the response
// is loaded into the output register. Claim and query walk the slots in use
// through the slot ram, one read per cycle; a claim stops at the first expired
// slot and a query stops at the first slot already due. A new request is taken
// once the previous response has been loaded into the output register, which
// may still be waiting to be taken. Enable bits are flip-flops cleared by
// reset, so no clearing pass is needed after reset. slots_in_use may be written
// at any time the block is idle.
module periodic_timeout_table (
   input logic       clock,
   input logic       reset,
   ptt_req_if.sink   req_if,
   ptt_rsp_if.source rsp_if,
   ptt_csr_if.sink   csr_if
);
   import ptt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [USE_W-1:0]     use_ff;
   logic [SLOTS-1:0]     en_ff, en_in;

   logic [REQ_W-1:0]     op_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [TIME_W-1:0]    per_ff;
   logic [TIME_W-1:0]    now_ff;

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 pend_ff, pend_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;

   logic                 res_status_ff, res_status_in;
   logic                 res_found_ff, res_found_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff;
   logic                 rsp_found_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [WAIT_W-1:0]    rsp_wait_ff;
   logic                 rsp_load;

   // slot ram: period in the upper half, deadline in the lower half
   logic [2*TIME_W-1:0]  slot_mem [SLOTS];
   logic [2*TIME_W-1:0]  rd_data_ff;
   logic [SLOT_W-1:0]    rd_addr;
   logic                 mem_we;
   logic [SLOT_W-1:0]    wr_addr;
   logic [2*TIME_W-1:0]  wr_data;

   logic [CNT_W-1:0]     n_act;
   logic                 idx_ok;
   logic                 accept;
   logic [TIME_W-1:0]    rd_period;
   logic [TIME_W-1:0]    rd_deadline;
   logic [TIME_W-1:0]    since;
   logic [TIME_W-1:0]    ahead;

   assign n_act  = (use_ff > USE_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(use_ff);
   assign idx_ok = CNT_W'(idx_ff) < n_act && idx_ff < IDX_W'(SLOTS);
   assign accept = req_if.valid && req_if.ready;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;

   assign rd_period   = rd_data_ff[2*TIME_W-1:TIME_W];
   assign rd_deadline = rd_data_ff[TIME_W-1:0];
   assign since       = now_ff - rd_deadline;
   assign ahead       = rd_deadline - now_ff;

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      en_in         = en_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_slot_in  = pend_slot_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      wait_in       = wait_ff;
      rd_addr       = cnt_ff[SLOT_W-1:0];
      mem_we        = 1'b0;
      wr_addr       = idx_ff[SLOT_W-1:0];
      wr_data       = {per_ff, now_ff + per_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in        = '0;
               res_status_in = 1'b0;
               res_found_in  = 1'b0;
               res_slot_in   = '0;
               wait_in       = (req_code_type'(req_if.req_type) == REQ_QUERY) ?
                               NO_DEADLINE : '0;
               if (req_code_type'(req_if.req_type) == REQ_CLAIM ||
                   req_code_type'(req_if.req_type) == REQ_QUERY) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (req_code_type'(op_ff))
               REQ_ENABLE: begin
                  if (idx_ok) begin
                     mem_we                       = 1'b1;
                     en_in[idx_ff[SLOT_W-1:0]]    = 1'b1;
                  end else begin
                     res_status_in = 1'b1;
                  end
               end
               REQ_DISABLE: begin
                  if (idx_ok) begin
                     en_in[idx_ff[SLOT_W-1:0]] = 1'b0;
                  end else begin
                     res_status_in = 1'b1;
                  end
               end
               REQ_DISABLE_ALL: begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (CNT_W'(i) < n_act) begin
                        en_in[i] = 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            // issue the next read while judging the slot read last cycle
            if (cnt_ff < n_act) begin
               cnt_in       = cnt_ff + 1'b1;
               pend_in      = 1'b1;
               pend_slot_in = cnt_ff[SLOT_W-1:0];
            end else begin
               state_in = ST_DONE;
            end
            if (pend_ff && en_ff[pend_slot_ff]) begin
               if (req_code_type'(op_ff) == REQ_CLAIM) begin
                  if (!since[TIME_W-1]) begin
                     mem_we       = 1'b1;
                     wr_addr      = pend_slot_ff;
                     wr_data      = {rd_period, now_ff + rd_period};
                     res_found_in = 1'b1;
                     res_slot_in  = pend_slot_ff;
                     pend_in      = 1'b0;
                     state_in     = ST_DONE;
                  end
               end else begin
                  if (ahead == '0 || ahead[TIME_W-1]) begin
                     wait_in  = '0;
                     pend_in  = 1'b0;
                     state_in = ST_DONE;
                  end else if (ahead[WAIT_W-1:0] < wait_ff) begin
                     wait_in = ahead[WAIT_W-1:0];
                  end
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         use_ff       <= USE_RESET;
         en_ff        <= '0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         en_ff        <= en_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            use_ff <= csr_if.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_if.req_type;
         idx_ff <= req_if.slot_index;
         per_ff <= req_if.period;
         now_ff <= req_if.now;
      end
      pend_slot_ff  <= pend_slot_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      wait_ff       <= wait_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_wait_ff   <= wait_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.expired_found = rsp_found_ff;
   assign rsp_if.expired_slot  = rsp_slot_ff;
   assign rsp_if.wait_time     = rsp_wait_ff;

endmodule
